### sv/bmp_pixel_row_unpacker_defines.svh
// ---------------------------------------------------------------------------
// bmp_pixel_row_unpacker_defines
// assertion macros shared by the pixel row unpacker
// ---------------------------------------------------------------------------
`ifndef BMP_PIXEL_ROW_UNPACKER_DEFINES_SVH
`define BMP_PIXEL_ROW_UNPACKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define BPRU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bpru assertion failed");

// next-cycle implication, checked out of reset
`define BPRU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bpru assertion failed");

`endif

### sv/bpru_pkg.sv
// ---------------------------------------------------------------------------
// bpru_pkg
// types, constants and helpers for the bmp pixel row unpacker
// ---------------------------------------------------------------------------
package bpru_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;

    localparam int DIM_W       = 13;
    localparam int COORD_W     = 12;
    localparam int LINE_W      = 15;
    localparam int VALUE_W     = 32;
    localparam int KEY_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DIM_W-1:0] MAX_WIDTH_DIM  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_HEIGHT_DIM = DIM_W'(MAX_HEIGHT);

    // pixel depth modes
    localparam logic [1:0] MODE_4BPP  = 2'd0;
    localparam logic [1:0] MODE_8BPP  = 2'd1;
    localparam logic [1:0] MODE_24BPP = 2'd2;
    localparam logic [1:0] MODE_32BPP = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_UP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_KEY = 3'd4;

    typedef struct packed {
        logic [1:0]       depth_mode;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             bottom_up;
        logic [KEY_W-1:0] key;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               done;
    } pix_t;

    typedef struct packed {
        logic [1:0] valid;
        pix_t       p1;
        pix_t       p0;
    } pix_pair_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### sv/bpru_decode.sv
// ---------------------------------------------------------------------------
// bpru_decode
// row/column/pixel counters and the per-byte decode into up to two pixels
// ---------------------------------------------------------------------------
module bpru_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  bpru_pkg::cfg_t      cfg,
    input  logic                clear,
    input  logic                step,
    input  logic [7:0]          data_byte,
    output bpru_pkg::pix_pair_t pix
);

    logic [1:0]                     byte_in_pixel_reg, byte_in_pixel_next;
    logic [bpru_pkg::KEY_W-1:0]     pixel_assembly_reg, pixel_assembly_next;
    logic [bpru_pkg::COORD_W-1:0]   column_count_reg, column_count_next;
    logic [bpru_pkg::COORD_W-1:0]   row_count_reg, row_count_next;
    logic [bpru_pkg::LINE_W-1:0]    byte_in_line_reg, byte_in_line_next;

    logic [bpru_pkg::DIM_W-1:0]     w, h;
    logic [bpru_pkg::COORD_W-1:0]   w_m1, h_m1;
    logic [bpru_pkg::LINE_W-1:0]    w_ext, w3, words, line_bytes, data_bytes, bil_p1;
    logic [bpru_pkg::COORD_W-1:0]   row_cur, row_out;
    logic [bpru_pkg::DIM_W-1:0]     row_p1, col_p1;
    logic                           done_row, in_data, two;
    logic [1:0]                     last_idx;
    logic [bpru_pkg::KEY_W-1:0]     rgb;

    always_comb begin
        w     = bpru_pkg::clamp_dim(cfg.width, bpru_pkg::MAX_WIDTH_DIM);
        h     = bpru_pkg::clamp_dim(cfg.height, bpru_pkg::MAX_HEIGHT_DIM);
        w_m1  = bpru_pkg::COORD_W'(w - bpru_pkg::DIM_W'(1));
        h_m1  = bpru_pkg::COORD_W'(h - bpru_pkg::DIM_W'(1));
        w_ext = bpru_pkg::LINE_W'(w);
        w3    = {w_ext[bpru_pkg::LINE_W-2:0], 1'b0} + w_ext;

        // 32-bit words per stored row, then bytes of pixel data per row
        case (cfg.depth_mode)
            bpru_pkg::MODE_4BPP: begin
                words      = (w_ext + 15'd7) >> 3;
                data_bytes = (w_ext + 15'd1) >> 1;
            end
            bpru_pkg::MODE_8BPP: begin
                words      = (w_ext + 15'd3) >> 2;
                data_bytes = w_ext;
            end
            bpru_pkg::MODE_24BPP: begin
                words      = (w3 + 15'd3) >> 2;
                data_bytes = w3;
            end
            default: begin
                words      = w_ext;
                data_bytes = {w_ext[bpru_pkg::LINE_W-3:0], 2'b00};
            end
        endcase
        line_bytes = {words[bpru_pkg::LINE_W-3:0], 2'b00};
    end

    always_comb begin
        row_cur  = ({1'b0, row_count_reg} >= h) ? '0 : row_count_reg;
        row_out  = cfg.bottom_up ? (h_m1 - row_cur) : row_cur;
        done_row = (row_cur == h_m1);
        in_data  = (byte_in_line_reg < data_bytes);
        col_p1   = bpru_pkg::DIM_W'(column_count_reg) + bpru_pkg::DIM_W'(1);
        two      = (col_p1 < w);
        last_idx = (cfg.depth_mode == bpru_pkg::MODE_24BPP) ? 2'd2 : 2'd3;
        rgb      = {data_byte, pixel_assembly_reg[15:0]};
        bil_p1   = byte_in_line_reg + 15'd1;
        row_p1   = bpru_pkg::DIM_W'(row_cur) + bpru_pkg::DIM_W'(1);

        pix                 = '0;
        pix.p0.row          = row_out;
        pix.p0.col          = column_count_reg;
        pix.p0.last         = 1'b1;
        pix.p0.done         = done_row && (column_count_reg == w_m1);
        pix.p1.row          = row_out;
        pix.p1.col          = col_p1[bpru_pkg::COORD_W-1:0];
        pix.p1.last         = 1'b1;
        pix.p1.done         = done_row && (col_p1[bpru_pkg::COORD_W-1:0] == w_m1);

        byte_in_pixel_next  = byte_in_pixel_reg;
        pixel_assembly_next = pixel_assembly_reg;
        column_count_next   = column_count_reg;
        row_count_next      = row_cur;
        byte_in_line_next   = bil_p1;

        if (in_data) begin
            case (cfg.depth_mode)
                bpru_pkg::MODE_4BPP: begin
                    // high nibble first, low nibble only if the row has room
                    pix.valid      = {two, 1'b1};
                    pix.p0.value   = {28'd0, data_byte[7:4]};
                    pix.p0.last    = !two;
                    pix.p0.done    = !two && done_row && (column_count_reg == w_m1);
                    pix.p1.value   = {28'd0, data_byte[3:0]};
                    column_count_next = two ? (column_count_reg + 12'd2)
                                            : (column_count_reg + 12'd1);
                end
                bpru_pkg::MODE_8BPP: begin
                    pix.valid         = 2'b01;
                    pix.p0.value      = {24'd0, data_byte};
                    column_count_next = column_count_reg + 12'd1;
                end
                default: begin
                    if (byte_in_pixel_reg < last_idx) begin
                        case (byte_in_pixel_reg)
                            2'd0:    pixel_assembly_next[7:0]   = data_byte;
                            2'd1:    pixel_assembly_next[15:8]  = data_byte;
                            default: pixel_assembly_next[23:16] = data_byte;
                        endcase
                        byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                    end else begin
                        pix.valid = 2'b01;
                        if (cfg.depth_mode == bpru_pkg::MODE_24BPP) begin
                            pix.p0.value = (rgb == cfg.key) ? '0 : {8'hFF, rgb};
                        end else begin
                            pix.p0.value = {data_byte, pixel_assembly_reg};
                        end
                        column_count_next   = column_count_reg + 12'd1;
                        byte_in_pixel_next  = '0;
                        pixel_assembly_next = '0;
                    end
                end
            endcase
        end

        // end of stored row, padding included
        if (bil_p1 >= line_bytes) begin
            byte_in_line_next   = '0;
            column_count_next   = '0;
            byte_in_pixel_next  = '0;
            pixel_assembly_next = '0;
            row_count_next      = (row_p1 >= h) ? '0 : row_p1[bpru_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            byte_in_pixel_reg  <= '0;
            pixel_assembly_reg <= '0;
            column_count_reg   <= '0;
            row_count_reg      <= '0;
            byte_in_line_reg   <= '0;
        end else if (step) begin
            byte_in_pixel_reg  <= byte_in_pixel_next;
            pixel_assembly_reg <= pixel_assembly_next;
            column_count_reg   <= column_count_next;
            row_count_reg      <= row_count_next;
            byte_in_line_reg   <= byte_in_line_next;
        end
    end

endmodule

### sv/bmp_pixel_row_unpacker.sv
// ---------------------------------------------------------------------------
// bmp_pixel_row_unpacker
// unpacks an uncompressed bmp pixel array byte stream into pixels with
// destination row and column (4/8/24/32 bpp, padding drop, row flip)
// ---------------------------------------------------------------------------
//  channel   handshake           payload
//  s_        s_valid / s_ready   s_data_byte
//  m_        m_valid / m_ready   m_out_row, m_out_column, m_pixel_value,
//                                m_last_of_byte, m_image_done
//  cfg_      cfg_we              cfg_index, cfg_wdata
//
// a byte goes into an input register, is decoded from there and its pixels
// land in a four-entry result queue that feeds the output port. one byte
// per cycle in 8/24/32 bpp while m_ready is high; in 4 bpp a byte can give
// two pixels, so the rate is set by the one-pixel-per-cycle output port
// draining the queue. decode waits while the queue holds more than two
// pixels; m_ready low backs up into s_ready. synchronous active-low reset;
// any register write restarts the image at row 0, column 0.
// ---------------------------------------------------------------------------
`include "bmp_pixel_row_unpacker_defines.svh"

module bmp_pixel_row_unpacker (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_we,
    input  logic [bpru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpru_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bpru_pkg::COORD_W-1:0]      m_out_row,
    output logic [bpru_pkg::COORD_W-1:0]      m_out_column,
    output logic [bpru_pkg::VALUE_W-1:0]      m_pixel_value,
    output logic                              m_last_of_byte,
    output logic                              m_image_done
);

    bpru_pkg::cfg_t                   cfg_reg;
    logic                             cfg_clear;

    logic                             in_valid_reg;
    logic [7:0]                       in_byte_reg;
    logic                             take;

    bpru_pkg::pix_pair_t              pix;
    bpru_pkg::pix_t                   q_reg [bpru_pkg::QUEUE_DEPTH];
    logic [bpru_pkg::Q_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [bpru_pkg::Q_CNT_W-1:0]     count_reg, count_next;
    logic [bpru_pkg::Q_CNT_W-1:0]     push_n;
    logic                             pop;
    bpru_pkg::pix_t                   head;

    // configuration registers
    assign cfg_clear = cfg_we && (cfg_index <= bpru_pkg::REG_TRANSPARENT_KEY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_mode <= bpru_pkg::MODE_8BPP;
            cfg_reg.width      <= bpru_pkg::DIM_W'(1);
            cfg_reg.height     <= bpru_pkg::DIM_W'(1);
            cfg_reg.bottom_up  <= 1'b1;
            cfg_reg.key        <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bpru_pkg::REG_DEPTH_MODE:      cfg_reg.depth_mode <= cfg_wdata[1:0];
                bpru_pkg::REG_IMAGE_WIDTH:     cfg_reg.width  <= cfg_wdata[bpru_pkg::DIM_W-1:0];
                bpru_pkg::REG_IMAGE_HEIGHT:    cfg_reg.height <= cfg_wdata[bpru_pkg::DIM_W-1:0];
                bpru_pkg::REG_BOTTOM_UP:       cfg_reg.bottom_up  <= cfg_wdata[0];
                bpru_pkg::REG_TRANSPARENT_KEY: cfg_reg.key <= cfg_wdata[bpru_pkg::KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign take    = in_valid_reg && (count_reg <= bpru_pkg::Q_CNT_W'(2));
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    bpru_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .clear     (cfg_clear),
        .step      (take),
        .data_byte (in_byte_reg),
        .pix       (pix)
    );

    // result queue
    assign head   = q_reg[rd_ptr_reg];
    assign pop    = m_valid && m_ready;
    assign push_n = take ? (bpru_pkg::Q_CNT_W'(pix.valid[0]) + bpru_pkg::Q_CNT_W'(pix.valid[1]))
                         : '0;
    assign count_next = count_reg + push_n - bpru_pkg::Q_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (take && pix.valid[0]) begin
            q_reg[wr_ptr_reg] <= pix.p0;
        end
        if (take && pix.valid[1]) begin
            q_reg[wr_ptr_reg + bpru_pkg::Q_PTR_W'(1)] <= pix.p1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n[bpru_pkg::Q_PTR_W-1:0];
            rd_ptr_reg <= rd_ptr_reg + bpru_pkg::Q_PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    assign m_valid        = (count_reg != '0);
    assign m_out_row      = head.row;
    assign m_out_column   = head.col;
    assign m_pixel_value  = head.value;
    assign m_last_of_byte = head.last;
    assign m_image_done   = head.done;

    // checks
    `BPRU_ASSERT_IMPL(a_queue_bound, aclk, aresetn, 1'b1,
                      count_reg <= bpru_pkg::Q_CNT_W'(bpru_pkg::QUEUE_DEPTH))
    `BPRU_ASSERT_IMPL(a_pair_only_4bpp, aclk, aresetn, take && pix.valid[1],
                      cfg_reg.depth_mode == bpru_pkg::MODE_4BPP && pix.valid[0])
    `BPRU_ASSERT_IMPL(a_done_is_last, aclk, aresetn, m_valid && m_image_done,
                      m_last_of_byte)
    `BPRU_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready && !cfg_clear,
                      m_valid && $stable(m_pixel_value) && $stable(m_out_column))

endmodule
